[hdl/skt_pkg.sv]
// shared widths, codes and controller/datapath interface types for the sorted key table
package skt_pkg;

	localparam int KEY_W        = 24;
	localparam int YEAR_W       = 12;
	localparam int CRED_W       = 10;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 3;
	localparam int ENTRY_W      = KEY_W + YEAR_W + CRED_W;
	localparam int TDATA_W      = ((ENTRY_W + 7) / 8) * 8;
	localparam int DEF_CAPACITY = 64;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN,
		OP_SHUP_INIT,
		OP_SHUP,
		OP_SHDN_INIT,
		OP_SHDN,
		OP_WRNEW,
		OP_WRUPD,
		OP_DEC,
		OP_LIST_RD
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic               emit;
		logic [STAT_W-1:0]  status;
		logic               use_data;
		logic               last;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_end;
		logic eq;
		logic full;
		logic empty;
		logic shup_done;
		logic shdn_done;
		logic list_last;
		logic out_free;
	} dp_sts_t;

endpackage

[hdl/skt_datapath.sv]
// entry memory, scan and shift counters, entry count and output word register
module skt_datapath #(
	parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skt_pkg::dp_cmd_t              cmd,
	output skt_pkg::dp_sts_t              sts,
	input  logic [skt_pkg::TDATA_W-1:0]   in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skt_pkg::TDATA_W-1:0]   out_data,
	output logic [skt_pkg::STAT_W-1:0]    out_user,
	output logic                          out_last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = skt_pkg::KEY_W;
	localparam int YW = skt_pkg::YEAR_W;
	localparam int RW = skt_pkg::CRED_W;
	localparam int EW = skt_pkg::ENTRY_W;

	logic [EW-1:0] mem_q [CAPACITY];
	logic [EW-1:0] rdata_q;

	logic [KW-1:0] key_q;
	logic [YW-1:0] year_q;
	logic [RW-1:0] cred_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [AW-1:0] wa_q;
	logic          rv_q;
	logic          eq_q;

	logic                           out_valid_q;
	logic [skt_pkg::TDATA_W-1:0]    out_data_q;
	logic [skt_pkg::STAT_W-1:0]     out_user_q;
	logic                           out_last_q;

	logic [KW-1:0] rd_key;
	logic [CW-1:0] idx_m1;
	logic          hit;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	assign rd_key = rdata_q[KW-1:0];
	assign idx_m1 = idx_q - CW'(1);
	assign hit    = rv_q && (rd_key >= key_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = wa_q;
		wr_data = rdata_q;
		unique case (cmd.op) inside
			skt_pkg::OP_SCAN: begin
				rd_en = !hit && (idx_q != count_q);
			end
			skt_pkg::OP_SHUP: begin
				rd_en   = (idx_q != pos_q);
				rd_addr = idx_m1[AW-1:0];
				wr_en   = rv_q;
			end
			skt_pkg::OP_SHDN: begin
				rd_en = (idx_q < count_q);
				wr_en = rv_q;
			end
			skt_pkg::OP_WRNEW, skt_pkg::OP_WRUPD: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = {cred_q, year_q, key_q};
			end
			skt_pkg::OP_LIST_RD: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op) inside
				skt_pkg::OP_LOAD, skt_pkg::OP_SHUP_INIT, skt_pkg::OP_SHDN_INIT: begin
					rv_q <= 1'b0;
				end
				skt_pkg::OP_SCAN, skt_pkg::OP_SHUP, skt_pkg::OP_SHDN: begin
					rv_q <= rd_en;
				end
				skt_pkg::OP_WRNEW: begin
					count_q <= count_q + CW'(1);
				end
				skt_pkg::OP_DEC: begin
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op) inside
			skt_pkg::OP_LOAD: begin
				key_q  <= in_data[KW-1:0];
				year_q <= in_data[KW+YW-1:KW];
				cred_q <= in_data[EW-1:KW+YW];
				idx_q  <= '0;
			end
			skt_pkg::OP_SCAN: begin
				if (hit) begin
					pos_q <= idx_m1;
					eq_q  <= (rd_key == key_q);
				end else if (idx_q == count_q) begin
					pos_q <= count_q;
					eq_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			skt_pkg::OP_SHUP_INIT: begin
				idx_q <= count_q;
			end
			skt_pkg::OP_SHUP: begin
				if (idx_q != pos_q) begin
					idx_q <= idx_m1;
					wa_q  <= idx_q[AW-1:0];
				end
			end
			skt_pkg::OP_SHDN_INIT: begin
				idx_q <= pos_q + CW'(1);
			end
			skt_pkg::OP_SHDN: begin
				if (idx_q < count_q) begin
					idx_q <= idx_q + CW'(1);
					wa_q  <= idx_m1[AW-1:0];
				end
			end
			skt_pkg::OP_LIST_RD: begin
				idx_q <= idx_q + CW'(1);
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			out_user_q <= cmd.status;
			out_data_q <= cmd.use_data ? skt_pkg::TDATA_W'(rdata_q) : '0;
			out_last_q <= cmd.last;
		end
	end

	always_comb begin
		sts.scan_hit  = hit;
		sts.scan_end  = !hit && (idx_q == count_q);
		sts.eq        = eq_q;
		sts.full      = (count_q == CW'(CAPACITY));
		sts.empty     = (count_q == '0);
		sts.shup_done = (idx_q == pos_q) && !rv_q;
		sts.shdn_done = (idx_q >= count_q) && !rv_q;
		sts.list_last = (idx_q == count_q);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

endmodule

[hdl/skt_ctrl.sv]
// command sequencer for the sorted key table
module skt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [skt_pkg::CMD_W-1:0]   in_cmd,
	output skt_pkg::dp_cmd_t            cmd,
	input  skt_pkg::dp_sts_t            sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHUP,
		S_SHDN,
		S_RESP,
		S_LRD,
		S_LEM
	} state_t;

	state_t                        state_q, state_n;
	logic [skt_pkg::CMD_W-1:0]     cmd_q, cmd_n;
	logic [skt_pkg::STAT_W-1:0]    res_status_q, res_status_n;
	logic                          res_data_q, res_data_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n      = state_q;
		cmd_n        = cmd_q;
		res_status_n = res_status_q;
		res_data_n   = res_data_q;
		cmd.op       = skt_pkg::OP_NONE;
		cmd.emit     = 1'b0;
		cmd.status   = skt_pkg::ST_OK;
		cmd.use_data = 1'b0;
		cmd.last     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = skt_pkg::OP_LOAD;
					cmd_n  = in_cmd;
					case (in_cmd) inside
						skt_pkg::CMD_LIST: begin
							if (sts.empty) begin
								res_status_n = skt_pkg::ST_EMPTY;
								res_data_n   = 1'b0;
								state_n      = S_RESP;
							end else begin
								state_n = S_LRD;
							end
						end
						skt_pkg::CMD_INSERT, skt_pkg::CMD_UPDATE,
						skt_pkg::CMD_REMOVE, skt_pkg::CMD_LOOKUP: begin
							state_n = S_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.op = skt_pkg::OP_SCAN;
				if (sts.scan_hit || sts.scan_end) begin
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_status_n = skt_pkg::ST_NOTFOUND;
				res_data_n   = 1'b0;
				state_n      = S_RESP;
				case (cmd_q) inside
					skt_pkg::CMD_INSERT: begin
						if (sts.eq) begin
							res_status_n = skt_pkg::ST_DUP;
						end else if (sts.full) begin
							res_status_n = skt_pkg::ST_FULL;
						end else begin
							cmd.op  = skt_pkg::OP_SHUP_INIT;
							state_n = S_SHUP;
						end
					end
					skt_pkg::CMD_UPDATE: begin
						if (sts.eq) begin
							cmd.op       = skt_pkg::OP_WRUPD;
							res_status_n = skt_pkg::ST_OK;
						end
					end
					skt_pkg::CMD_REMOVE: begin
						if (sts.eq) begin
							cmd.op  = skt_pkg::OP_SHDN_INIT;
							state_n = S_SHDN;
						end
					end
					skt_pkg::CMD_LOOKUP: begin
						if (sts.eq) begin
							res_status_n = skt_pkg::ST_OK;
							res_data_n   = 1'b1;
						end
					end
					default: begin
						state_n = S_IDLE;
					end
				endcase
			end
			S_SHUP: begin
				if (sts.shup_done) begin
					cmd.op       = skt_pkg::OP_WRNEW;
					res_status_n = skt_pkg::ST_OK;
					res_data_n   = 1'b0;
					state_n      = S_RESP;
				end else begin
					cmd.op = skt_pkg::OP_SHUP;
				end
			end
			S_SHDN: begin
				if (sts.shdn_done) begin
					cmd.op       = skt_pkg::OP_DEC;
					res_status_n = skt_pkg::ST_OK;
					res_data_n   = 1'b0;
					state_n      = S_RESP;
				end else begin
					cmd.op = skt_pkg::OP_SHDN;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.status   = res_status_q;
					cmd.use_data = res_data_q;
					cmd.last     = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_LRD: begin
				cmd.op  = skt_pkg::OP_LIST_RD;
				state_n = S_LEM;
			end
			S_LEM: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.status   = skt_pkg::ST_OK;
					cmd.use_data = 1'b1;
					cmd.last     = sts.list_last;
					state_n      = sts.list_last ? S_IDLE : S_LRD;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= skt_pkg::CMD_INSERT;
			res_status_q <= skt_pkg::ST_OK;
			res_data_q   <= 1'b0;
		end else begin
			state_q      <= state_n;
			cmd_q        <= cmd_n;
			res_status_q <= res_status_n;
			res_data_q   <= res_data_n;
		end
	end

endmodule

[hdl/sorted_key_table_top.sv]
// top level of the sorted key table: sequencer plus entry datapath
// The table keeps up to CAPACITY entries in ascending key order in a single-port-read,
// single-port-write memory, and takes one command word at a time: s_tready is high only
// while no command is in progress. Insert, update, remove and lookup first scan the table
// from the lowest key, one entry per cycle through the registered memory read. Insert then
// shifts the later entries up and remove shifts them down, one entry per cycle. The scan
// stops at the slot of the key and the shift only moves the entries above it, so together
// they make one pass over the table. List reads each entry and then emits it, waiting
// while the output word is not taken. Each result word waits in an output register; the
// sequencer only stalls on it when the next result is ready. No clearing pass is needed
// after reset: only entries below the entry count are ever read.
module sorted_key_table_top #(
	parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skt_pkg::TDATA_W-1:0]   s_tdata,  // key, year, credits
	input  logic [skt_pkg::CMD_W-1:0]     s_tuser,  // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skt_pkg::TDATA_W-1:0]   m_tdata,  // found_key, found_year, found_credits
	output logic [skt_pkg::STAT_W-1:0]    m_tuser,  // status
	output logic                          m_tlast
);

	skt_pkg::dp_cmd_t dp_cmd;
	skt_pkg::dp_sts_t dp_sts;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.cmd      (dp_cmd),
		.sts      (dp_sts)
	);

	skt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

[hdl/skt_checker.sv]
// port-level checks of the sorted key table, bound to its top level
module skt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [skt_pkg::CMD_W-1:0]     s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [skt_pkg::TDATA_W-1:0]   m_tdata,
	input logic [skt_pkg::STAT_W-1:0]    m_tuser,
	input logic                          m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// error and empty results carry no entry and end the command
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != skt_pkg::ST_OK) |-> m_tlast && (m_tdata == '0))
		else $error("non-ok result with data or without last");

	// only list entries come without last, and they are ok
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tuser == skt_pkg::ST_OK))
		else $error("non-final result not ok");

	// a valid command keeps the input closed on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == skt_pkg::CMD_INSERT
			|| s_tuser == skt_pkg::CMD_UPDATE || s_tuser == skt_pkg::CMD_REMOVE
			|| s_tuser == skt_pkg::CMD_LOOKUP || s_tuser == skt_pkg::CMD_LIST)
		|=> !s_tready)
		else $error("input open while command in progress");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (.*);
